// ===== sv/lsrd_pkg.sv =====
// Shared types and constants for the linked sparse row dot product block.
// No dependencies; imported by every module of the block.
package lsrd_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_ROWS    = 1024;
  localparam int ENT_AW      = $clog2(MAX_ENTRIES);
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int CNT_W       = ENT_AW + 1;
  localparam int ROW_W       = 10;
  localparam int COL_W       = 16;
  localparam int VAL_W       = 16;
  localparam int SUM_W       = 48;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 56;

  // Opcode carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_APPEND  = 2'd0,
    ST_REPLACE = 2'd1,
    ST_DROP    = 2'd2,
    ST_PAIR    = 2'd3
  } status_t;

  // Command class decided by the front end
  typedef enum logic [1:0] {
    K_LOAD = 2'd0,
    K_PAIR = 2'd1,
    K_DROP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     a_ok;
    logic                     b_ok;
    logic [ROW_W-1:0]         row_a;
    logic [ROW_W-1:0]         row_b;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  val;
  } cmd_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

  typedef struct packed {
    logic pop;
    logic busy_clear;
  } q_ctl_t;

  typedef struct packed {
    logic                     last;
    logic [ENT_AW-1:0]        nxt;
    logic signed [VAL_W-1:0]  weight;
    logic [COL_W-1:0]         col;
  } entry_t;

  typedef struct packed {
    logic              used;
    logic [ENT_AW-1:0] head;
  } row_t;

endpackage

// ===== sv/lsrd_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on lsrd_pkg.
module lsrd_front
  import lsrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // row_index, col_index, entry_value, other_row
  input  logic                  in_tuser,  // opcode
  input  q_ctl_t                ctl,
  output q_out_t                q_out
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  cmd_t       cmd_in;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    cmd_in.row_a = in_tdata[ROW_W-1:0];
    cmd_in.col   = in_tdata[ROW_W +: COL_W];
    cmd_in.val   = in_tdata[ROW_W+COL_W +: VAL_W];
    cmd_in.row_b = in_tdata[ROW_W+COL_W+VAL_W +: ROW_W];
    cmd_in.a_ok  = {1'b0, cmd_in.row_a} < (ROW_W+1)'(MAX_ROWS);
    cmd_in.b_ok  = {1'b0, cmd_in.row_b} < (ROW_W+1)'(MAX_ROWS);
    if (in_tuser == OP_PAIR) begin
      cmd_in.kind = K_PAIR;
    end else if (!cmd_in.a_ok) begin
      cmd_in.kind = K_DROP;
    end else begin
      cmd_in.kind = K_LOAD;
    end
  end

  assign in_tready = !ctl.busy_clear && (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign q_out.valid = (fill_r != 2'd0);
  assign q_out.cmd   = q_mem_r[rd_ptr_r];

endmodule

// ===== sv/lsrd_back.sv =====
// Back end: row/entry stores, list walker for loads and pair merges, result register.
// Depends on lsrd_pkg; fed by lsrd_front through its command queue.
module lsrd_back
  import lsrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_out_t                q_in,
  output q_ctl_t                ctl,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // dot_sum, sum_positive
  output logic [1:0]            out_tuser   // status
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_LD_HEAD = 12'b0000_0000_0010,
    S_LD_WALK = 12'b0000_0000_0100,
    S_LD_APP  = 12'b0000_0000_1000,
    S_PR_HA   = 12'b0000_0001_0000,
    S_PR_HB   = 12'b0000_0010_0000,
    S_PR_A0   = 12'b0000_0100_0000,
    S_PR_A    = 12'b0000_1000_0000,
    S_PR_B    = 12'b0001_0000_0000,
    S_PR_CMP  = 12'b0010_0000_0000,
    S_PR_ACC  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  // Stores
  row_t   row_mem [MAX_ROWS];
  entry_t ent_mem [MAX_ENTRIES];
  row_t   row_q;
  entry_t ent_q;

  logic              row_we;
  logic [ROW_AW-1:0] row_waddr, row_raddr;
  row_t              row_wdata;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_waddr, ent_raddr;
  entry_t            ent_wdata;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic                     clr_r, clr_nxt;
  logic [ROW_AW-1:0]        clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ENT_AW-1:0]        cur_r, cur_nxt;
  logic [ENT_AW-1:0]        b_idx_r, b_idx_nxt;
  logic                     a_live_r, a_live_nxt;
  entry_t                   ea_r, ea_nxt;
  entry_t                   eb_r, eb_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  status_t                  res_r, res_nxt;
  logic                     ov_r, ov_nxt;
  logic [SUM_W-1:0]         osum_r, osum_nxt;
  status_t                  ost_r, ost_nxt;
  logic                     full;
  logic signed [SUM_W:0]    sum_ext;
  logic                     slot_free;

  assign full      = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign slot_free = !ov_r || out_tready;
  assign sum_ext   = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(prod_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    clr_nxt        = clr_r;
    clr_idx_nxt    = clr_idx_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    b_idx_nxt      = b_idx_r;
    a_live_nxt     = a_live_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    prod_nxt       = prod_r;
    sum_nxt        = sum_r;
    res_nxt        = res_r;
    ov_nxt         = ov_r && !out_tready;
    osum_nxt       = osum_r;
    ost_nxt        = ost_r;
    row_we         = 1'b0;
    row_waddr      = clr_idx_r;
    row_wdata      = '0;
    row_raddr      = q_in.cmd.row_a[ROW_AW-1:0];
    ent_we         = 1'b0;
    ent_waddr      = cur_r;
    ent_wdata      = '0;
    ent_raddr      = cur_r;
    ctl.pop        = 1'b0;
    ctl.busy_clear = clr_r;

    if (clr_r) begin
      // Sweep row heads to empty after reset
      row_we      = 1'b1;
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == ROW_AW'(MAX_ROWS - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (!clr_r && q_in.valid) begin
          ctl.pop = 1'b1;
          cmd_nxt = q_in.cmd;
          sum_nxt = '0;
          case (q_in.cmd.kind)
            K_LOAD: state_nxt = S_LD_HEAD;
            K_PAIR: state_nxt = S_PR_HA;
            default: begin
              res_nxt   = ST_DROP;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LD_HEAD: begin
        if (!row_q.used) begin
          if (full) begin
            res_nxt = ST_DROP;
          end else begin
            row_we         = 1'b1;
            row_waddr      = cmd_r.row_a[ROW_AW-1:0];
            row_wdata.used = 1'b1;
            row_wdata.head = cnt_r[ENT_AW-1:0];
            ent_we         = 1'b1;
            ent_waddr      = cnt_r[ENT_AW-1:0];
            ent_wdata      = '{last: 1'b1, nxt: '0, weight: cmd_r.val, col: cmd_r.col};
            cnt_nxt        = cnt_r + 1'b1;
            res_nxt        = ST_APPEND;
          end
          state_nxt = S_DONE;
        end else begin
          ent_raddr = row_q.head;
          cur_nxt   = row_q.head;
          state_nxt = S_LD_WALK;
        end
      end
      S_LD_WALK: begin
        if (ent_q.col == cmd_r.col) begin
          // Replace weight in place
          ent_we    = 1'b1;
          ent_wdata = '{last: ent_q.last, nxt: ent_q.nxt, weight: cmd_r.val, col: ent_q.col};
          res_nxt   = ST_REPLACE;
          state_nxt = S_DONE;
        end else if (ent_q.last) begin
          if (full) begin
            res_nxt   = ST_DROP;
            state_nxt = S_DONE;
          end else begin
            // Link old tail to the new entry
            ent_we    = 1'b1;
            ent_wdata = '{last: 1'b0, nxt: cnt_r[ENT_AW-1:0], weight: ent_q.weight,
                          col: ent_q.col};
            state_nxt = S_LD_APP;
          end
        end else begin
          ent_raddr = ent_q.nxt;
          cur_nxt   = ent_q.nxt;
        end
      end
      S_LD_APP: begin
        ent_we    = 1'b1;
        ent_waddr = cnt_r[ENT_AW-1:0];
        ent_wdata = '{last: 1'b1, nxt: '0, weight: cmd_r.val, col: cmd_r.col};
        cnt_nxt   = cnt_r + 1'b1;
        res_nxt   = ST_APPEND;
        state_nxt = S_DONE;
      end
      S_PR_HA: begin
        a_live_nxt = cmd_r.a_ok && row_q.used;
        cur_nxt    = row_q.head;
        row_raddr  = cmd_r.row_b[ROW_AW-1:0];
        state_nxt  = S_PR_HB;
      end
      S_PR_HB: begin
        res_nxt = ST_PAIR;
        if (a_live_r && cmd_r.b_ok && row_q.used) begin
          ent_raddr = cur_r;
          b_idx_nxt = row_q.head;
          state_nxt = S_PR_A0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PR_A0: begin
        ea_nxt    = ent_q;
        ent_raddr = b_idx_r;
        state_nxt = S_PR_B;
      end
      S_PR_A: begin
        ea_nxt    = ent_q;
        state_nxt = S_PR_CMP;
      end
      S_PR_B: begin
        eb_nxt    = ent_q;
        state_nxt = S_PR_CMP;
      end
      S_PR_CMP: begin
        if (ea_r.col < eb_r.col) begin
          // Advance A; stop when A runs out
          if (ea_r.last) begin
            state_nxt = S_DONE;
          end else begin
            ent_raddr = ea_r.nxt;
            state_nxt = S_PR_A;
          end
        end else if (ea_r.col == eb_r.col) begin
          prod_nxt  = ea_r.weight * eb_r.weight;
          state_nxt = S_PR_ACC;
        end else if (eb_r.last) begin
          state_nxt = S_DONE;
        end else begin
          ent_raddr = eb_r.nxt;
          state_nxt = S_PR_B;
        end
      end
      S_PR_ACC: begin
        // Saturating accumulate, then advance B
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          sum_nxt = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
        if (eb_r.last) begin
          state_nxt = S_DONE;
        end else begin
          ent_raddr = eb_r.nxt;
          state_nxt = S_PR_B;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_r;
          osum_nxt  = sum_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
      cnt_r     <= cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    cur_r    <= cur_nxt;
    b_idx_r  <= b_idx_nxt;
    a_live_r <= a_live_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    prod_r   <= prod_nxt;
    sum_r    <= sum_nxt;
    res_r    <= res_nxt;
    osum_r   <= osum_nxt;
    ost_r    <= ost_nxt;
  end

  // Row head store
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_q <= ent_mem[ent_raddr];
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {{(OUT_DATA_W-SUM_W-1){1'b0}},
                       (!osum_r[SUM_W-1] && (osum_r != '0)), osum_r};

endmodule

// ===== sv/linked_sparse_row_dot_product.sv =====
// Sparse matrix in per-row linked lists with row-pair dot product.
// A load walks the row's entries, with one more step to append to a nonempty row; a pair
// with an empty row ends at once, else merges both lists; output stalls add delay.
// Throughput: one item at a time in the back end, which walks the entry store lists
// serially; a two-deep command queue takes beats meanwhile.
// Reset: synchronous, active low; then a clear of all 1024 row heads, in_tready low.
module linked_sparse_row_dot_product
  import lsrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_index, col_index, entry_value, other_row
  input  logic                  in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // dot_sum, sum_positive
  output logic [1:0]            out_tuser   // status
);

  q_out_t q_out;
  q_ctl_t q_ctl;

  lsrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctl       (q_ctl),
    .q_out     (q_out)
  );

  lsrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_out),
    .ctl        (q_ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== bench/linked_sparse_row_dot_product_test.sv =====
// Self-checking bench for linked_sparse_row_dot_product: loads and row-pair dot products.
// It predicts every result in a local model of the linked entry store and checks each beat.
// Depends on lsrd_pkg and the linked_sparse_row_dot_product RTL.
module linked_sparse_row_dot_product_test;
  import lsrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int IDLE_LIMIT = 60000;
  localparam int POOL = 24;

  typedef struct {
    status_t            status;
    logic signed [47:0] dot_sum;
    logic               positive;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;  // row_index, col_index, entry_value, other_row
  logic                  in_tuser = 1'b0; // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // dot_sum, sum_positive
  logic [1:0]            out_tuser;      // status

  // Local copy of the entry store
  logic [COL_W-1:0]        m_col  [MAX_ENTRIES];
  logic signed [VAL_W-1:0] m_wt   [MAX_ENTRIES];
  int                      m_nxt  [MAX_ENTRIES];
  bit                      m_last [MAX_ENTRIES];
  int                      m_head [MAX_ROWS];
  bit                      m_used [MAX_ROWS];
  int                      m_count;

  result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int last_col [POOL];

  linked_sparse_row_dot_product i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Insert or replace one entry in the local store
  function automatic status_t model_load(int row, logic [15:0] col, logic signed [15:0] w);
    int e;
    if (row >= MAX_ROWS) return ST_DROP;
    if (m_used[row]) begin
      e = m_head[row];
      for (int s = 0; s < MAX_ENTRIES; s++) begin
        if (m_col[e] == col) begin
          m_wt[e] = w;
          return ST_REPLACE;
        end
        if (m_last[e]) break;
        e = m_nxt[e];
      end
      if (m_count >= MAX_ENTRIES) return ST_DROP;
      m_nxt[e] = m_count;
      m_last[e] = 1'b0;
    end else begin
      if (m_count >= MAX_ENTRIES) return ST_DROP;
      m_head[row] = m_count;
      m_used[row] = 1'b1;
    end
    m_col[m_count] = col;
    m_wt[m_count] = w;
    m_nxt[m_count] = 0;
    m_last[m_count] = 1'b1;
    m_count++;
    return ST_APPEND;
  endfunction

  // Merge walk along row B, advancing row A; stop once A or B runs out
  function automatic longint model_pair(int ra, int rb);
    longint sum = 0;
    bit a_live = 0, b_live = 0;
    int a = 0, b = 0, sa = 0;
    if (ra < MAX_ROWS && m_used[ra]) begin a_live = 1; a = m_head[ra]; end
    if (rb < MAX_ROWS && m_used[rb]) begin b_live = 1; b = m_head[rb]; end
    for (int sb = 0; b_live && sb < MAX_ENTRIES; sb++) begin
      while (a_live && m_col[a] < m_col[b]) begin
        sa++;
        if (m_last[a] || sa >= MAX_ENTRIES) a_live = 0;
        else a = m_nxt[a];
      end
      if (!a_live) break;
      if (m_col[a] == m_col[b]) begin
        sum += longint'(int'(m_wt[a]) * int'(m_wt[b]));
        if (sum > SUM_HI) sum = SUM_HI;
        if (sum < SUM_LO) sum = SUM_LO;
      end
      if (m_last[b]) b_live = 0;
      else b = m_nxt[b];
    end
    return sum;
  endfunction

  // Offer one beat, wait for acceptance, then queue its expected result
  task automatic send_item(logic op, logic [9:0] row, logic [15:0] col,
                           logic signed [15:0] val, logic [9:0] orow);
    result_t r;
    longint s;
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, orow, val, col, row};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      r.status = model_load(row, col, val);
      r.dot_sum = '0;
      r.positive = 1'b0;
    end else begin
      s = model_pair(row, orow);
      r.status = ST_PAIR;
      r.dot_sum = s[47:0];
      r.positive = s > 0;
    end
    pending_results.insert(pending_results.size(), r);
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t x;
    if (out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: tuser %0d tdata %h",
                                       out_tuser, out_tdata);
      end else begin
        x = pending_results.pop_front();
        if (out_tuser != x.status || out_tdata[47:0] != x.dot_sum ||
            out_tdata[48] != x.positive || out_tdata[55:49] != '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d sum %0d pos %0d, got %0d %0d %0d (%h)",
                     x.status, x.dot_sum, x.positive, out_tuser,
                     $signed(out_tdata[47:0]), out_tdata[48], out_tdata);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("linked_sparse_row_dot_product_test: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_PAIR, 10'd0, 16'hFFFF, 16'sh7FFF, 10'd1);       // both rows empty
    send_item(OP_LOAD, 10'd0, 16'd0, 16'sh7FFF, 10'h3FF);
    send_item(OP_LOAD, 10'd0, 16'd5, -16'sd32768, 10'd0);
    send_item(OP_LOAD, 10'd0, 16'hFFFF, 16'sh0100, 10'd0);
    send_item(OP_LOAD, 10'd0, 16'hFFFF, -16'sd256, 10'd0);      // match on last entry
    send_item(OP_LOAD, 10'd0, 16'd0, -16'sd32768, 10'd0);       // replace at head
    send_item(OP_LOAD, 10'h3FF, 16'd0, -16'sd32768, 10'h3FF);
    send_item(OP_LOAD, 10'h3FF, 16'd5, -16'sd32768, 10'd0);
    send_item(OP_LOAD, 10'h3FF, 16'hFFFF, 16'sh7FFF, 10'd0);
    send_item(OP_PAIR, 10'd0, 16'd0, 16'sd0, 10'h3FF);
    send_item(OP_PAIR, 10'h3FF, 16'hFFFF, 16'sh7FFF, 10'd0);
    send_item(OP_PAIR, 10'd0, 16'd0, 16'sd0, 10'd0);            // row with itself
    send_item(OP_PAIR, 10'd0, 16'd0, 16'sd0, 10'd2);            // B empty
    send_item(OP_PAIR, 10'd2, 16'd0, 16'sd0, 10'd0);            // A empty
    send_item(OP_LOAD, 10'd2, 16'd100, 16'sd1, 10'd0);
    send_item(OP_LOAD, 10'd2, 16'd50, 16'sd3, 10'd0);           // columns not ascending
    send_item(OP_LOAD, 10'd2, 16'd5, 16'sd7, 10'd0);
    send_item(OP_PAIR, 10'd2, 16'd0, 16'sd0, 10'd0);
    send_item(OP_PAIR, 10'd0, 16'd0, 16'sd0, 10'd2);
    send_item(OP_LOAD, 10'd3, 16'd5, -16'sd1, 10'd0);
    send_item(OP_PAIR, 10'd3, 16'd0, 16'sd0, 10'h3FF);          // positive sum from two negative weights
  endtask

  task automatic random_item();
    int p;
    logic [9:0] row, orow;
    logic [15:0] col;
    p = $urandom_range(POOL - 1);
    row = ($urandom_range(9) < 8) ? 10'(16 + p) : 10'($urandom);
    orow = ($urandom_range(9) < 8) ? 10'(16 + $urandom_range(POOL - 1)) : 10'($urandom);
    if ($urandom_range(9) < 6) begin
      if (row == 16 + p && $urandom_range(9) < 8 && last_col[p] < 65000) begin
        last_col[p] += $urandom_range(1, 40);
        col = 16'(last_col[p]);
      end else if (row == 16 + p && $urandom_range(1) == 1) begin
        col = 16'($urandom_range(last_col[p]));                  // likely a replace
      end else begin
        col = 16'($urandom);
      end
      send_item(OP_LOAD, row, col, 16'($urandom), orow);
    end else begin
      send_item(OP_PAIR, row, 16'($urandom), 16'($urandom), orow);
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) random_item();
  endtask

  // Long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_cycles = 400;
    test_random(40);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    for (int r = 0; r < MAX_ROWS; r++) m_used[r] = 1'b0;
    for (int e = 0; e < MAX_ENTRIES; e++) m_last[e] = 1'b0;
    for (int p = 0; p < POOL; p++) last_col[p] = 0;
    m_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 18; stall_pct = 53;
    test_directed();
    test_random(440);
    send_gap_pct = 53; stall_pct = 18;
    test_random(440);
    test_backpressure();
    send_gap_pct = 0; stall_pct = 0;
    test_random(440);
    in_tvalid <= 1'b0;
    drain();

    $display("covered appends, replaces, unordered columns and pair sums under stalls; %0d results",
             results_seen);
    if (mismatches == 0) $display("linked_sparse_row_dot_product_test: done, clean");
    else begin
      $display("%0d mismatches", mismatches);
      $display("linked_sparse_row_dot_product_test: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/lsrd_pkg.sv
sv/lsrd_front.sv
sv/lsrd_back.sv
sv/linked_sparse_row_dot_product.sv
bench/linked_sparse_row_dot_product_test.sv
